FILE: rtl/core/isl_pkg.sv
package isl_pkg;

	typedef enum logic [4:0] {
		PH_REST, PH_HASH, PH_LCOM, PH_BC, PH_BC_HASH, PH_BC_BRACE,
		PH_NUM_INT, PH_NUM_DOT, PH_NUM_FRAC, PH_NUM_E, PH_NUM_ESIGN, PH_NUM_EXP,
		PH_IDENT, PH_OP2, PH_STR_TEXT, PH_STR_DOL_FRESH, PH_STR_DOL_TEXT,
		PH_STR_BSLASH
	} phase_t;

	localparam logic [4:0] K_EOF = 5'd0;
	localparam logic [4:0] K_NUMBER = 5'd1;
	localparam logic [4:0] K_IDENT = 5'd2;
	localparam logic [4:0] K_PLUS = 5'd3;
	localparam logic [4:0] K_MINUS = 5'd4;
	localparam logic [4:0] K_SLASH = 5'd5;
	localparam logic [4:0] K_LPAREN = 5'd6;
	localparam logic [4:0] K_RPAREN = 5'd7;
	localparam logic [4:0] K_LBRACE = 5'd8;
	localparam logic [4:0] K_RBRACE = 5'd9;
	localparam logic [4:0] K_COMMA = 5'd10;
	localparam logic [4:0] K_SEMI = 5'd11;
	localparam logic [4:0] K_STAR = 5'd12;
	localparam logic [4:0] K_ASSIGN = 5'd14;
	localparam logic [4:0] K_NOT = 5'd16;
	localparam logic [4:0] K_LESS = 5'd18;
	localparam logic [4:0] K_GREATER = 5'd20;
	localparam logic [4:0] K_STR_START = 5'd22;
	localparam logic [4:0] K_STR_END = 5'd23;
	localparam logic [4:0] K_INTERP_START = 5'd24;
	localparam logic [4:0] K_CONTENT = 5'd25;
	localparam logic [4:0] K_INTERP_END = 5'd26;
	localparam logic [4:0] K_ERROR = 5'd27;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_BAD_NUMBER = 2'd1;
	localparam logic [1:0] E_UNRECOGNIZED = 2'd2;
	localparam logic [1:0] E_UNTERMINATED = 2'd3;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic [1:0]  err;
		logic        ovf;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
	endfunction

	function automatic logic [4:0] single_kind(input logic [7:0] c);
		case (c)
			8'h2a: return K_STAR;
			8'h3d: return K_ASSIGN;
			8'h21: return K_NOT;
			8'h3c: return K_LESS;
			default: return K_GREATER;
		endcase
	endfunction

	function automatic logic [15:0] span(input logic [15:0] b, input logic [15:0] e);
		return (e > b) ? e - b : 16'd0;
	endfunction

endpackage

FILE: rtl/core/isl_scan.sv
module isl_scan import isl_pkg::*; #(
	parameter int MODE_STACK_DEPTH = 16,
	parameter int MAX_COMMENT_NESTING = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  byte_value,
	input  logic        end_of_text,
	output token_t      tok [3],
	output logic [1:0]  tok_n
);

	localparam int DW = $clog2(MODE_STACK_DEPTH + 1);
	localparam int AW = $clog2(MODE_STACK_DEPTH);
	localparam int NW = $clog2(MAX_COMMENT_NESTING + 1);
	localparam logic [DW-1:0] DMAX = DW'(MODE_STACK_DEPTH);
	localparam logic [NW-1:0] NMAX = NW'(MAX_COMMENT_NESTING);

	phase_t           phase_q, phase_d;
	logic [MODE_STACK_DEPTH-1:0] stack_q, stack_d;
	logic [DW-1:0]    depth_q, depth_d;
	logic [NW-1:0]    nest_q, nest_d;
	logic [15:0]      line_q, line_d, off_q, off_d, begin_q, begin_d;
	logic [7:0]       held_q, held_d;

	// one step of the scanner: current phase, then possibly a rest pass
	always_comb begin
		logic rest;
		logic [15:0] hoff;
		logic [15:0] tl;
		logic top_str;
		logic [7:0] b;
		logic push_ovf;
		b = byte_value;
		phase_d = phase_q; stack_d = stack_q; depth_d = depth_q; nest_d = nest_q;
		line_d = line_q; off_d = off_q; begin_d = begin_q; held_d = held_q;
		tok_n = 2'd0;
		for (int i = 0; i < 3; i++) tok[i] = '0;
		rest = 1'b0;
		hoff = (off_q > 16'd0) ? off_q - 16'd1 : 16'd0;
		top_str = stack_q[AW'(depth_q - DW'(1))];
		push_ovf = depth_q >= DMAX;
		tl = line_q;
		if (end_of_text) begin
			// flush pending token, unterminated string, eof
			case (phase_q)
				PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXP: begin
					tok[0] = '{K_NUMBER, begin_q, span(begin_q, off_q), tl, E_NONE, 1'b0};
					tok_n = 2'd1;
				end
				PH_NUM_DOT: begin
					tok[0] = '{K_NUMBER, begin_q, span(begin_q, hoff), tl, E_NONE, 1'b0};
					tok[1] = '{K_ERROR, hoff, 16'd1, tl, E_UNRECOGNIZED, 1'b0};
					tok_n = 2'd2;
				end
				PH_NUM_E, PH_NUM_ESIGN: begin
					tok[0] = '{K_ERROR, begin_q, span(begin_q, off_q), tl, E_BAD_NUMBER, 1'b0};
					tok_n = 2'd1;
				end
				PH_IDENT: begin
					tok[0] = '{K_IDENT, begin_q, span(begin_q, off_q), tl, E_NONE, 1'b0};
					tok_n = 2'd1;
				end
				PH_OP2: begin
					tok[0] = '{single_kind(held_q), begin_q, 16'd1, tl, E_NONE, 1'b0};
					tok_n = 2'd1;
				end
				PH_STR_TEXT, PH_STR_DOL_FRESH, PH_STR_DOL_TEXT, PH_STR_BSLASH: begin
					tok[0] = '{K_CONTENT, begin_q, span(begin_q, off_q), tl, E_NONE, 1'b0};
					tok_n = 2'd1;
				end
				default: ;
			endcase
			if (top_str) begin
				tok[tok_n] = '{K_ERROR, off_q, 16'd0, tl, E_UNTERMINATED, 1'b0};
				tok_n = tok_n + 2'd1;
			end
			tok[tok_n] = '{K_EOF, off_q, 16'd0, tl, E_NONE, 1'b0};
			tok_n = tok_n + 2'd1;
			phase_d = PH_REST; stack_d = '0; depth_d = DW'(1); nest_d = '0;
			line_d = 16'd1; off_d = 16'd0; begin_d = 16'd0; held_d = 8'd0;
		end else begin
			if (off_q != 16'hffff) off_d = off_q + 16'd1;
			case (phase_q)
				PH_HASH: begin
					if (b == 8'h7b) begin nest_d = NW'(1); phase_d = PH_BC; end
					else if (b == 8'h0a) rest = 1'b1;
					else phase_d = PH_LCOM;
				end
				PH_LCOM: if (b == 8'h0a) rest = 1'b1;
				PH_BC, PH_BC_HASH, PH_BC_BRACE: begin
					if (phase_q == PH_BC_HASH && b == 8'h7b) begin
						if (nest_q < NMAX) nest_d = nest_q + NW'(1);
						phase_d = PH_BC;
					end else if (phase_q == PH_BC_BRACE && b == 8'h23) begin
						nest_d = (nest_q > '0) ? nest_q - NW'(1) : nest_q;
						phase_d = (nest_d == '0) ? PH_REST : PH_BC;
					end else begin
						phase_d = PH_BC;
						if (b == 8'h23) phase_d = PH_BC_HASH;
						else if (b == 8'h7d) phase_d = PH_BC_BRACE;
						else if (b == 8'h0a && line_q != 16'hffff) line_d = line_q + 16'd1;
					end
				end
				PH_NUM_INT, PH_NUM_FRAC: begin
					if (!is_digit(b)) begin
						if (b == 8'h2e && phase_q == PH_NUM_INT) phase_d = PH_NUM_DOT;
						else if (b == 8'h65 || b == 8'h45) phase_d = PH_NUM_E;
						else begin
							tok[0] = '{K_NUMBER, begin_q, span(begin_q, off_q), tl, E_NONE, 1'b0};
							tok_n = 2'd1; rest = 1'b1;
						end
					end
				end
				PH_NUM_DOT: begin
					if (is_digit(b)) phase_d = PH_NUM_FRAC;
					else begin
						tok[0] = '{K_NUMBER, begin_q, span(begin_q, hoff), tl, E_NONE, 1'b0};
						tok[1] = '{K_ERROR, hoff, 16'd1, tl, E_UNRECOGNIZED, 1'b0};
						tok_n = 2'd2; rest = 1'b1;
					end
				end
				PH_NUM_E, PH_NUM_ESIGN: begin
					if (is_digit(b)) phase_d = PH_NUM_EXP;
					else if (phase_q == PH_NUM_E && (b == 8'h2b || b == 8'h2d))
						phase_d = PH_NUM_ESIGN;
					else begin
						tok[0] = '{K_ERROR, begin_q, span(begin_q, off_q), tl, E_BAD_NUMBER, 1'b0};
						tok_n = 2'd1; rest = 1'b1;
					end
				end
				PH_NUM_EXP, PH_IDENT: begin
					if (!(is_digit(b) || (phase_q == PH_IDENT && is_alpha(b)))) begin
						tok[0] = '{(phase_q == PH_IDENT) ? K_IDENT : K_NUMBER, begin_q,
							span(begin_q, off_q), tl, E_NONE, 1'b0};
						tok_n = 2'd1; rest = 1'b1;
					end
				end
				PH_OP2: begin
					if (b == 8'h3d) begin
						tok[0] = '{single_kind(held_q) + 5'd1, begin_q, 16'd2, tl, E_NONE, 1'b0};
						tok_n = 2'd1; phase_d = PH_REST;
					end else begin
						tok[0] = '{single_kind(held_q), begin_q, 16'd1, tl, E_NONE, 1'b0};
						tok_n = 2'd1; rest = 1'b1;
					end
				end
				PH_STR_TEXT, PH_STR_DOL_FRESH, PH_STR_DOL_TEXT, PH_STR_BSLASH: begin
					if (phase_q != PH_STR_TEXT && b == 8'h7b && phase_q != PH_STR_BSLASH) begin
						if (phase_q == PH_STR_DOL_TEXT) begin
							tok[0] = '{K_CONTENT, begin_q, span(begin_q, hoff), tl, E_NONE, 1'b0};
							tok[1] = '{K_INTERP_START, hoff, 16'd2, tl, E_NONE, push_ovf};
							tok_n = 2'd2;
						end else begin
							tok[0] = '{K_INTERP_START, begin_q, 16'd2, tl, E_NONE, push_ovf};
							tok_n = 2'd1;
						end
						if (!push_ovf) begin
							stack_d[AW'(depth_q)] = 1'b0;
							depth_d = depth_q + DW'(1);
						end
						phase_d = PH_REST;
					end else if (phase_q == PH_STR_BSLASH && (b == 8'h22 || b == 8'h24)) begin
						phase_d = PH_STR_TEXT;
					end else begin
						phase_d = PH_STR_TEXT;
						if (b == 8'h22) begin
							tok[0] = '{K_CONTENT, begin_q, span(begin_q, off_q), tl, E_NONE, 1'b0};
							tok[1] = '{K_STR_END, off_q, 16'd1, tl, E_NONE, 1'b0};
							tok_n = 2'd2;
							if (depth_q > DW'(1)) depth_d = depth_q - DW'(1);
							phase_d = PH_REST;
						end else if (b == 8'h24) phase_d = PH_STR_DOL_TEXT;
						else if (b == 8'h5c) phase_d = PH_STR_BSLASH;
					end
				end
				default: rest = 1'b1;
			endcase
			// byte starts anew from rest
			if (rest) begin
				begin_d = off_q;
				phase_d = PH_REST;
				if (top_str && phase_q != PH_HASH && phase_q != PH_LCOM) begin
					if (b == 8'h22) begin
						tok[tok_n] = '{K_STR_END, off_q, 16'd1, tl, E_NONE, 1'b0};
						tok_n = tok_n + 2'd1;
						if (depth_q > DW'(1)) depth_d = depth_q - DW'(1);
					end else if (b == 8'h24) phase_d = PH_STR_DOL_FRESH;
					else if (b == 8'h5c) phase_d = PH_STR_BSLASH;
					else phase_d = PH_STR_TEXT;
				end else begin
					case (b)
						8'h20, 8'h09, 8'h0d: ;
						8'h0a: if (line_q != 16'hffff) line_d = line_q + 16'd1;
						8'h23: phase_d = PH_HASH;
						8'h2a, 8'h3d, 8'h21, 8'h3c, 8'h3e: begin
							held_d = b; phase_d = PH_OP2;
						end
						8'h22: begin
							tok[tok_n] = '{K_STR_START, off_q, 16'd1, tl, E_NONE, push_ovf};
							tok_n = tok_n + 2'd1;
							if (!push_ovf) begin
								stack_d[AW'(depth_q)] = 1'b1;
								depth_d = depth_q + DW'(1);
							end
						end
						default: begin
							if (is_digit(b)) phase_d = PH_NUM_INT;
							else if (is_alpha(b)) phase_d = PH_IDENT;
							else begin
								logic [4:0] k;
								logic [1:0] e;
								e = E_NONE;
								case (b)
									8'h2b: k = K_PLUS;
									8'h2d: k = K_MINUS;
									8'h2f: k = K_SLASH;
									8'h28: k = K_LPAREN;
									8'h29: k = K_RPAREN;
									8'h7b: k = K_LBRACE;
									8'h7d: begin
										if (depth_q > DW'(1)) begin
											k = K_INTERP_END;
											depth_d = depth_q - DW'(1);
										end else k = K_RBRACE;
									end
									8'h2c: k = K_COMMA;
									8'h3b: k = K_SEMI;
									default: begin k = K_ERROR; e = E_UNRECOGNIZED; end
								endcase
								tok[tok_n] = '{k, off_q, 16'd1, tl, e, 1'b0};
								tok_n = tok_n + 2'd1;
							end
						end
					endcase
				end
			end
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_REST; stack_q <= '0; depth_q <= DW'(1); nest_q <= '0;
			line_q <= 16'd1; off_q <= 16'd0; begin_q <= 16'd0; held_q <= 8'd0;
		end else if (take) begin
			phase_q <= phase_d; stack_q <= stack_d; depth_q <= depth_d; nest_q <= nest_d;
			line_q <= line_d; off_q <= off_d; begin_q <= begin_d; held_q <= held_d;
		end
	end

endmodule

FILE: rtl/core/isl_outq.sv
module isl_outq import isl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  token_t      tok [3],
	input  logic [1:0]  tok_n,
	output logic        out_valid,
	input  logic        out_stall,
	output token_t      out_tok,
	output logic        out_last
);

	// fifo of tokens, 8 slots
	token_t      mem_q [8];
	logic        last_q [8];
	logic [2:0]  wp_q, rp_q;
	logic [3:0]  cnt_q;
	logic        pop;

	assign out_valid = cnt_q != 4'd0;
	assign out_tok = mem_q[rp_q];
	assign out_last = last_q[rp_q];
	assign pop = out_valid && !out_stall;
	// stall unless three slots are free without the one leaving
	assign in_stall = cnt_q > 4'd5;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			for (int i = 0; i < 3; i++) begin
				if (2'(i) < tok_n) begin
					mem_q[wp_q + 3'(i)] <= tok[i];
					last_q[wp_q + 3'(i)] <= (2'(i) == tok_n - 2'd1);
				end
			end
		end
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			logic [3:0] add;
			add = (in_valid && !in_stall) ? {2'b0, tok_n} : 4'd0;
			wp_q <= wp_q + add[2:0];
			if (pop) rp_q <= rp_q + 3'd1;
			cnt_q <= cnt_q + add - {3'b0, pop};
		end
	end

endmodule

FILE: rtl/core/interpolating_string_lexer.sv
// interpolating string lexer
// a token is written into the token queue when the byte that decides it is taken
// throughput: one byte per cycle; up to three tokens per byte drain at one per
// cycle while out_stall is low through an eight-entry token queue, which stalls input when nearly full
// reset: arst_n clears scanner state, mode stack and queue at once
module interpolating_string_lexer import isl_pkg::*; #(
	parameter int MODE_STACK_DEPTH = 16,
	parameter int MAX_COMMENT_NESTING = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic [1:0]  error_kind,
	output logic        mode_overflow,
	output logic        last_of_run
);

	token_t     tok [3];
	token_t     otok;
	logic [1:0] tok_n;

	// scanner
	isl_scan #(
		.MODE_STACK_DEPTH(MODE_STACK_DEPTH),
		.MAX_COMMENT_NESTING(MAX_COMMENT_NESTING)
	) u_scan (
		.clk, .arst_n,
		.take(in_valid && !in_stall),
		.byte_value, .end_of_text,
		.tok, .tok_n
	);

	// token queue
	isl_outq u_outq (
		.clk, .arst_n,
		.in_valid, .in_stall,
		.tok, .tok_n,
		.out_valid, .out_stall,
		.out_tok(otok), .out_last(last_of_run)
	);

	assign token_kind = otok.kind;
	assign token_start = otok.start;
	assign token_length = otok.length;
	assign token_line = otok.line;
	assign error_kind = otok.err;
	assign mode_overflow = otok.ovf;

endmodule
